// ----- design/vtcb_pkg.sv -----
// ----------------------------------------------------------------------------
// vtcb_pkg
// shared types, constants and helpers of the threshold and crop box block
// ----------------------------------------------------------------------------
package vtcb_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_DIM     = 1024;
  localparam int DIM_W       = 11;
  localparam int POS_W       = $clog2(MAX_DIM);
  localparam int BIN_W       = 31;
  localparam int SUM_W       = 46;
  localparam int PROD_W      = BIN_W + SAMPLE_BITS;
  localparam int THR_W       = 17;
  localparam int WALK_W      = SAMPLE_BITS + 1;
  localparam int BIN_COUNT   = 1 << SAMPLE_BITS;
  localparam int CFG_IDX_W   = 2;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [BIN_W-1:0] BIN_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = CFG_IDX_W'(2);

  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

  typedef enum logic [1:0] {
    CMD_HIST   = 2'd0,
    CMD_THRESH = 2'd1,
    CMD_BOX    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_WALK,
    OP_BOX,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    HS_INIT,
    HS_IDLE,
    HS_COUNT_WR,
    HS_CLEAR,
    HS_WALK,
    HS_RESULT
  } hist_state_e;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] sample;
  } in_data_t;

  typedef struct packed {
    logic             result_kind;
    logic [THR_W-1:0] threshold;
    logic [9:0]       x_low;
    logic [9:0]       x_high;
    logic [9:0]       y_low;
    logic [9:0]       y_high;
    logic [10:0]      z_low;
    logic [9:0]       z_high;
    logic             box_empty;
  } out_data_t;

  typedef struct packed {
    op_e                    op;
    logic [SAMPLE_BITS-1:0] sample;
  } queue_entry_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic                   start;
    op_e                    op;
    logic [SAMPLE_BITS-1:0] sample;
  } hist_cmd_t;

  typedef struct packed {
    logic             idle;
    logic             init_busy;
    logic             res_valid;
    logic [THR_W-1:0] thr;
  } hist_stat_t;

  typedef struct packed {
    logic                   sample_go;
    logic                   restart;
    logic [SAMPLE_BITS-1:0] sample;
  } box_cmd_t;

  // zero acts as one, anything above the largest dimension is clamped
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- design/volume_threshold_crop_box.sv -----
// ----------------------------------------------------------------------------
// volume_threshold_crop_box
// box sample: queued, then its result goes to the output register; one box sample
//   per cycle while the histogram engine is idle and the output slot is free
// histogram sample: a read-modify-write on the bin memory
// threshold: bin walk through a read/multiply/accumulate/compare pipe, one bin per cycle
// reset and clear: a sweep writes each of the 65536 bins to zero; after reset
//   no transfer is taken until the sweep is done, register writes always are
// ----------------------------------------------------------------------------
module volume_threshold_crop_box (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  vtcb_pkg::in_data_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output vtcb_pkg::out_data_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [vtcb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vtcb_pkg::DIM_W-1:0]        cfg_data_i
);

  // queue head from the front end
  logic                   head_valid;
  vtcb_pkg::queue_entry_t head;
  logic                   pop;

  // back end control
  vtcb_pkg::hist_cmd_t    hist_cmd;
  vtcb_pkg::hist_stat_t   hist_stat;
  vtcb_pkg::box_cmd_t     box_cmd;
  vtcb_pkg::cfg_wr_t      cfg_wr;
  logic                   box_res_valid;
  vtcb_pkg::out_data_t    box_res;
  vtcb_pkg::out_data_t    thr_res;

  // output register
  logic                   out_valid_q, out_valid_d;
  vtcb_pkg::out_data_t    out_data_q, out_data_d;
  logic                   slot_free;
  logic                   hist_go, box_go;

  assign slot_free = !out_valid_q || out_ready_i;

  vtcb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .hold_i       (hist_stat.init_busy),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // dispatch in order: everything waits for the histogram engine, so a box
  // sample never sees a threshold that is still being worked out; a box
  // sample also needs the output register, since it may finish a volume
  always_comb begin
    hist_go = 1'b0;
    box_go  = 1'b0;
    case (head.op)
      vtcb_pkg::OP_COUNT, vtcb_pkg::OP_WALK, vtcb_pkg::OP_CLEAR: begin
        hist_go = head_valid && hist_stat.idle;
      end
      vtcb_pkg::OP_BOX: begin
        box_go = head_valid && hist_stat.idle && slot_free;
      end
      default: begin
      end
    endcase
  end

  assign pop = hist_go || box_go;

  assign hist_cmd.start  = hist_go;
  assign hist_cmd.op     = head.op;
  assign hist_cmd.sample = head.sample;

  // clear also restarts the box scan
  assign box_cmd.sample_go = box_go;
  assign box_cmd.restart   = hist_go && (head.op == vtcb_pkg::OP_CLEAR);
  assign box_cmd.sample    = head.sample;

  assign cfg_wr.we    = cfg_we_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  vtcb_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (hist_cmd),
    .res_ready_i (slot_free),
    .stat_o      (hist_stat)
  );

  vtcb_box u_box (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .cmd_i       (box_cmd),
    .thr_i       (hist_stat.thr),
    .res_valid_o (box_res_valid),
    .res_o       (box_res)
  );

  // threshold result carries nothing but the threshold
  always_comb begin
    thr_res             = '0;
    thr_res.result_kind = vtcb_pkg::KIND_THRESH;
    thr_res.threshold   = hist_stat.thr;
  end

  // output register loads whenever the slot is free and a result is offered
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (slot_free) begin
      out_valid_d = hist_stat.res_valid || box_res_valid;
      if (hist_stat.res_valid) begin
        out_data_d = thr_res;
      end else if (box_res_valid) begin
        out_data_d = box_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the two result sources never compete for the output register
  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hist_stat.res_valid && box_res_valid))
    else $error("threshold and box results offered together");

  // a box sample only goes when its result cannot be lost
  a_box_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_go |-> slot_free)
    else $error("box sample dispatched without a free output slot");

  // no transfer taken during the initial bin sweep
  a_init_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_stat.init_busy |-> !in_ready_o)
    else $error("input taken during initial clear");

  // a pop always has something to take
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

// ----- design/vtcb_ram.sv -----
// ----------------------------------------------------------------------------
// vtcb_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vtcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/vtcb_front.sv -----
// ----------------------------------------------------------------------------
// vtcb_front
// input side: takes transfers, classifies the command, queues the operation
// ----------------------------------------------------------------------------
module vtcb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  vtcb_pkg::in_data_t     in_data_i,
  input  logic                   hold_i,
  output logic                   head_valid_o,
  output vtcb_pkg::queue_entry_t head_o,
  input  logic                   pop_i
);

  vtcb_pkg::queue_entry_t             fifo_q [vtcb_pkg::QDEPTH];
  vtcb_pkg::queue_entry_t             entry;
  logic [vtcb_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [vtcb_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [vtcb_pkg::QCNT_W-1:0]        count_q, count_d;
  logic                               push;

  // command decode
  always_comb begin
    entry.sample = in_data_i.sample[vtcb_pkg::SAMPLE_BITS-1:0];
    case (in_data_i.command)
      vtcb_pkg::CMD_HIST:   entry.op = vtcb_pkg::OP_COUNT;
      vtcb_pkg::CMD_THRESH: entry.op = vtcb_pkg::OP_WALK;
      vtcb_pkg::CMD_BOX:    entry.op = vtcb_pkg::OP_BOX;
      vtcb_pkg::CMD_CLEAR:  entry.op = vtcb_pkg::OP_CLEAR;
      default:              entry.op = vtcb_pkg::OP_BOX;
    endcase
  end

  assign in_ready_o   = (count_q != vtcb_pkg::QCNT_W'(vtcb_pkg::QDEPTH)) && !hold_i;
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ----- design/vtcb_hist.sv -----
// ----------------------------------------------------------------------------
// vtcb_hist
// histogram engine: bin memory, clear sweep, counting and threshold walk
// ----------------------------------------------------------------------------
module vtcb_hist (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vtcb_pkg::hist_cmd_t  cmd_i,
  input  logic                 res_ready_i,
  output vtcb_pkg::hist_stat_t stat_o
);

  localparam int SB = vtcb_pkg::SAMPLE_BITS;

  vtcb_pkg::hist_state_e              state_q, state_d;
  logic [SB-1:0]                      sweep_q, sweep_d;
  logic [SB-1:0]                      bin_addr_q, bin_addr_d;
  logic [vtcb_pkg::SUM_W-1:0]         total_q, total_d;
  logic [vtcb_pkg::THR_W-1:0]         thr_q, thr_d;
  logic [vtcb_pkg::WALK_W-1:0]        rd_q, rd_d;
  logic [vtcb_pkg::SUM_W-1:0]         run_q, run_d;
  logic                               v1_q, v2_q, v3_q;
  logic                               v1_d, v2_d, v3_d;
  logic [SB-1:0]                      t1_q, t2_q, t3_q;
  logic [vtcb_pkg::PROD_W-1:0]        prod_q;

  logic                               ram_we;
  logic [SB-1:0]                      ram_waddr, ram_raddr;
  logic [vtcb_pkg::BIN_W-1:0]         ram_wdata, ram_rdata;

  logic                               in_walk, issue, found, none;
  logic [vtcb_pkg::SUM_W:0]           total_sum;
  logic [vtcb_pkg::PROD_W:0]          run_sum;

  vtcb_ram #(
    .WIDTH (vtcb_pkg::BIN_W),
    .DEPTH (vtcb_pkg::BIN_COUNT)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_walk   = (state_q == vtcb_pkg::HS_WALK);
  assign issue     = in_walk && !rd_q[SB];
  assign ram_raddr = in_walk ? rd_q[SB-1:0] : cmd_i.sample;

  // saturating sums
  assign total_sum = {1'b0, total_q} + (vtcb_pkg::SUM_W + 1)'(bin_addr_q);
  assign run_sum   = (vtcb_pkg::PROD_W + 1)'(run_q) + (vtcb_pkg::PROD_W + 1)'(prod_q);

  // first bin where twice the running sum passes the total
  assign found = v3_q && ({run_q, 1'b0} > {1'b0, total_q});
  assign none  = v3_q && !found && (t3_q == '1);

  assign v1_d = issue;
  assign v2_d = v1_q && in_walk;
  assign v3_d = v2_q && in_walk;

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    bin_addr_d = bin_addr_q;
    total_d    = total_q;
    thr_d      = thr_q;
    rd_d       = rd_q;
    run_d      = run_q;
    ram_we     = 1'b0;
    ram_waddr  = sweep_q;
    ram_wdata  = '0;

    if (v2_q) begin
      if (run_sum > (vtcb_pkg::PROD_W + 1)'(vtcb_pkg::SUM_MAX)) begin
        run_d = vtcb_pkg::SUM_MAX;
      end else begin
        run_d = run_sum[vtcb_pkg::SUM_W-1:0];
      end
    end
    if (issue) begin
      rd_d = rd_q + 1'b1;
    end

    case (state_q)
      vtcb_pkg::HS_INIT, vtcb_pkg::HS_CLEAR: begin
        ram_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          state_d = vtcb_pkg::HS_IDLE;
        end
      end
      vtcb_pkg::HS_IDLE: begin
        if (cmd_i.start) begin
          case (cmd_i.op)
            vtcb_pkg::OP_COUNT: begin
              bin_addr_d = cmd_i.sample;
              state_d    = vtcb_pkg::HS_COUNT_WR;
            end
            vtcb_pkg::OP_WALK: begin
              rd_d    = '0;
              run_d   = '0;
              state_d = vtcb_pkg::HS_WALK;
            end
            vtcb_pkg::OP_CLEAR: begin
              total_d = '0;
              thr_d   = '0;
              sweep_d = '0;
              state_d = vtcb_pkg::HS_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      vtcb_pkg::HS_COUNT_WR: begin
        ram_waddr = bin_addr_q;
        ram_wdata = ram_rdata + 1'b1;
        if (ram_rdata != vtcb_pkg::BIN_MAX) begin
          ram_we = 1'b1;
          if (total_sum > (vtcb_pkg::SUM_W + 1)'(vtcb_pkg::SUM_MAX)) begin
            total_d = vtcb_pkg::SUM_MAX;
          end else begin
            total_d = total_sum[vtcb_pkg::SUM_W-1:0];
          end
        end
        state_d = vtcb_pkg::HS_IDLE;
      end
      vtcb_pkg::HS_WALK: begin
        if (found) begin
          thr_d   = vtcb_pkg::THR_W'(t3_q);
          state_d = vtcb_pkg::HS_RESULT;
        end else if (none) begin
          thr_d   = vtcb_pkg::THR_W'(vtcb_pkg::BIN_COUNT);
          state_d = vtcb_pkg::HS_RESULT;
        end
      end
      vtcb_pkg::HS_RESULT: begin
        if (res_ready_i) begin
          state_d = vtcb_pkg::HS_IDLE;
        end
      end
      default: begin
        state_d = vtcb_pkg::HS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vtcb_pkg::HS_INIT;
      sweep_q <= '0;
      total_q <= '0;
      thr_q   <= '0;
      rd_q    <= '0;
      run_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      total_q <= total_d;
      thr_q   <= thr_d;
      rd_q    <= rd_d;
      run_q   <= run_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      v3_q    <= v3_d;
    end
  end

  // walk pipe payload: read tag, product, accumulate tag
  always_ff @(posedge clk_i) begin
    bin_addr_q <= bin_addr_d;
    t1_q       <= rd_q[SB-1:0];
    t2_q       <= t1_q;
    t3_q       <= t2_q;
    prod_q     <= vtcb_pkg::PROD_W'(ram_rdata) * vtcb_pkg::PROD_W'(t1_q);
  end

  assign stat_o.idle      = (state_q == vtcb_pkg::HS_IDLE);
  assign stat_o.init_busy = (state_q == vtcb_pkg::HS_INIT);
  assign stat_o.res_valid = (state_q == vtcb_pkg::HS_RESULT);
  assign stat_o.thr       = thr_q;

endmodule

// ----- design/vtcb_box.sv -----
// ----------------------------------------------------------------------------
// vtcb_box
// crop box tracker: dimension registers, scan position and extent trackers
// ----------------------------------------------------------------------------
module vtcb_box (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vtcb_pkg::cfg_wr_t            cfg_i,
  input  vtcb_pkg::box_cmd_t           cmd_i,
  input  logic [vtcb_pkg::THR_W-1:0]   thr_i,
  output logic                         res_valid_o,
  output vtcb_pkg::out_data_t          res_o
);

  localparam int DW = vtcb_pkg::DIM_W;
  localparam int PW = vtcb_pkg::POS_W;
  localparam logic [PW-1:0] DIM_RESET_LAST = PW'(vtcb_pkg::eff_dim(vtcb_pkg::DIM_RESET) - 1'b1);

  logic [DW-1:0] width_q, width_d, height_q, height_d, depth_q, depth_d;
  logic [PW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [PW-1:0] lx_q, lx_d, gx_q, gx_d, ly_q, ly_d, gy_q, gy_d;
  logic [DW-1:0] front_q, front_d;
  logic [PW-1:0] back_q, back_d;
  logic          slice_hit_q, slice_hit_d, any_hit_q, any_hit_d;

  logic [DW-1:0] w, h, d, w_n, h_n, d_n;
  logic [PW-1:0] xp, yp, zp, w_last, h_last;
  logic [DW-1:0] x_inc, y_inc, z_inc;
  logic          hit, do_restart;

  assign w = vtcb_pkg::eff_dim(width_q);
  assign h = vtcb_pkg::eff_dim(height_q);
  assign d = vtcb_pkg::eff_dim(depth_q);
  assign w_last = PW'(w - 1'b1);
  assign h_last = PW'(h - 1'b1);

  // positions beyond a shrunk dimension wrap to zero
  assign xp = ({1'b0, x_q} >= w) ? '0 : x_q;
  assign yp = ({1'b0, y_q} >= h) ? '0 : y_q;
  assign zp = ({1'b0, z_q} >= d) ? '0 : z_q;
  assign x_inc = {1'b0, xp} + 1'b1;
  assign y_inc = {1'b0, yp} + 1'b1;
  assign z_inc = {1'b0, zp} + 1'b1;
  assign hit = ({1'b0, cmd_i.sample} > thr_i);

  assign w_n = vtcb_pkg::eff_dim(width_d);
  assign h_n = vtcb_pkg::eff_dim(height_d);
  assign d_n = vtcb_pkg::eff_dim(depth_d);

  // register writes
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    if (cfg_i.we) begin
      case (cfg_i.index)
        vtcb_pkg::REG_WIDTH:  width_d  = cfg_i.data;
        vtcb_pkg::REG_HEIGHT: height_d = cfg_i.data;
        vtcb_pkg::REG_DEPTH:  depth_d  = cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    lx_d        = lx_q;
    gx_d        = gx_q;
    ly_d        = ly_q;
    gy_d        = gy_q;
    front_d     = front_q;
    back_d      = back_q;
    slice_hit_d = slice_hit_q;
    any_hit_d   = any_hit_q;
    do_restart  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (cfg_i.we) begin
      do_restart = (cfg_i.index inside {vtcb_pkg::REG_WIDTH, vtcb_pkg::REG_HEIGHT,
                                        vtcb_pkg::REG_DEPTH});
    end else if (cmd_i.restart) begin
      do_restart = 1'b1;
    end else if (cmd_i.sample_go) begin
      if (hit) begin
        if (xp < lx_q) lx_d = xp;
        if (xp > gx_q) gx_d = xp;
        if (yp < ly_q) ly_d = yp;
        if (yp > gy_q) gy_d = yp;
        slice_hit_d = 1'b1;
        any_hit_d   = 1'b1;
      end
      x_d = x_inc[PW-1:0];
      y_d = yp;
      z_d = zp;
      if (x_inc >= w) begin
        x_d = '0;
        y_d = y_inc[PW-1:0];
        if (y_inc >= h) begin
          // end of a slice
          y_d = '0;
          if (slice_hit_d) begin
            back_d = zp;
          end else if (front_q == {1'b0, zp}) begin
            front_d = z_inc;
          end
          slice_hit_d = 1'b0;
          if (z_inc >= d) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = vtcb_pkg::KIND_BOX;
            res_o.threshold   = thr_i;
            res_o.x_low       = (lx_d < w_last) ? lx_d : w_last;
            res_o.x_high      = gx_d;
            res_o.y_low       = (ly_d < h_last) ? ly_d : h_last;
            res_o.y_high      = gy_d;
            res_o.z_low       = front_d;
            res_o.z_high      = back_d;
            res_o.box_empty   = !any_hit_d;
            do_restart        = 1'b1;
          end else begin
            z_d = z_inc[PW-1:0];
          end
        end
      end
    end

    if (do_restart) begin
      x_d         = '0;
      y_d         = '0;
      z_d         = '0;
      lx_d        = PW'(w_n - 1'b1);
      gx_d        = '0;
      ly_d        = PW'(h_n - 1'b1);
      gy_d        = '0;
      front_d     = '0;
      back_d      = PW'(d_n - 1'b1);
      slice_hit_d = 1'b0;
      any_hit_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= vtcb_pkg::DIM_RESET;
      height_q    <= vtcb_pkg::DIM_RESET;
      depth_q     <= vtcb_pkg::DIM_RESET;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      lx_q        <= DIM_RESET_LAST;
      gx_q        <= '0;
      ly_q        <= DIM_RESET_LAST;
      gy_q        <= '0;
      front_q     <= '0;
      back_q      <= DIM_RESET_LAST;
      slice_hit_q <= 1'b0;
      any_hit_q   <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      depth_q     <= depth_d;
      x_q         <= x_d;
      y_q         <= y_d;
      z_q         <= z_d;
      lx_q        <= lx_d;
      gx_q        <= gx_d;
      ly_q        <= ly_d;
      gy_q        <= gy_d;
      front_q     <= front_d;
      back_q      <= back_d;
      slice_hit_q <= slice_hit_d;
      any_hit_q   <= any_hit_d;
    end
  end

endmodule

// ----- bench/volume_threshold_crop_box_test.sv -----
// ----------------------------------------------------------------------------
// volume_threshold_crop_box_test
// self-checking bench for the voxel threshold and crop box block: a short
// scripted run, then random volumes over several geometries and idle
// patterns, every output transfer compared field by field with a typed row
// result or with a bench-side copy of the histogram, threshold walk and box trackers
// ----------------------------------------------------------------------------
module volume_threshold_crop_box_test;
  timeunit 1ns;
  timeprecision 1ps;

  // longest silent stretch: clear sweep plus a full bin walk, several times over
  localparam int WATCHDOG_LIMIT = 300000;
  // a clear may still be sweeping the bins after the last result has arrived
  localparam int SWEEP_WAIT     = 65600;
  localparam int SETTLE_WAIT    = 32;
  localparam int PHASE_ITEMS    = 125;
  localparam logic [vtcb_pkg::CFG_IDX_W-1:0] REG_SPARE = vtcb_pkg::CFG_IDX_W'(3);
  localparam logic [vtcb_pkg::THR_W-1:0]     NO_LEVEL  = vtcb_pkg::THR_W'(65536);
  localparam logic [vtcb_pkg::THR_W-1:0]     TOP_LEVEL = vtcb_pkg::THR_W'(65535);

  // results that can be read straight off the scripted rows
  localparam vtcb_pkg::out_data_t THR_NONE = '{vtcb_pkg::KIND_THRESH, NO_LEVEL, 10'd0,
                                               10'd0, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0};
  localparam vtcb_pkg::out_data_t THR_TOP  = '{vtcb_pkg::KIND_THRESH, TOP_LEVEL, 10'd0,
                                               10'd0, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0};
  // 2 x 1 x 2 volume with nothing above the level
  localparam vtcb_pkg::out_data_t BOX_VOID_NONE = '{vtcb_pkg::KIND_BOX, NO_LEVEL, 10'd1,
                                                    10'd0, 10'd0, 10'd0, 11'd2, 10'd1, 1'b1};
  localparam vtcb_pkg::out_data_t BOX_VOID_TOP  = '{vtcb_pkg::KIND_BOX, TOP_LEVEL, 10'd1,
                                                    10'd0, 10'd0, 10'd0, 11'd2, 10'd1, 1'b1};

  typedef struct packed {
    vtcb_pkg::cmd_e      command;
    logic [15:0]         sample;
    logic                typed;
    vtcb_pkg::out_data_t want;
  } script_row_t;

  // scripted part, run on a 2 x 1 x 2 volume straight after reset
  script_row_t script_rows [23] = '{
    '{vtcb_pkg::CMD_THRESH, 16'h1234, 1'b1, THR_NONE},      // empty histogram: no level
    '{vtcb_pkg::CMD_BOX,    16'hFFFF, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'h0000, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'h8000, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'hFFFF, 1'b1, BOX_VOID_NONE}, // nothing can exceed 65536
    '{vtcb_pkg::CMD_HIST,   16'hFFFF, 1'b0, '0},
    '{vtcb_pkg::CMD_THRESH, 16'h0000, 1'b1, THR_TOP},       // single top bin, full walk
    '{vtcb_pkg::CMD_BOX,    16'hFFFF, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'h0000, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'hFFFF, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'h7FFF, 1'b1, BOX_VOID_TOP},  // equal to the level is not above
    '{vtcb_pkg::CMD_CLEAR,  16'hFFFF, 1'b0, '0},
    '{vtcb_pkg::CMD_HIST,   16'h0003, 1'b0, '0},
    '{vtcb_pkg::CMD_HIST,   16'h0005, 1'b0, '0},
    '{vtcb_pkg::CMD_HIST,   16'h0003, 1'b0, '0},
    '{vtcb_pkg::CMD_HIST,   16'h0000, 1'b0, '0},            // zero counts but adds no weight
    '{vtcb_pkg::CMD_THRESH, 16'hAAAA, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'h0000, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'h0004, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'hFFFF, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'h0003, 1'b0, '0},
    '{vtcb_pkg::CMD_BOX,    16'h5555, 1'b0, '0},            // partial volume, dropped by next write
    '{vtcb_pkg::CMD_BOX,    16'hAAAA, 1'b0, '0}
  };

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  vtcb_pkg::in_data_t                 in_data_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  vtcb_pkg::out_data_t                out_data_o;
  logic                               cfg_we_i;
  logic [vtcb_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [vtcb_pkg::DIM_W-1:0]         cfg_data_i;

  volume_threshold_crop_box DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // bench-side copy of the block state
  // --------------------------------------------------------------------------
  logic [vtcb_pkg::BIN_W-1:0] bin_count [vtcb_pkg::BIN_COUNT];
  logic [vtcb_pkg::SUM_W-1:0] weight_total;
  logic [vtcb_pkg::SUM_W-1:0] weight_run;
  logic [vtcb_pkg::THR_W-1:0] thr_level;
  logic [10:0]                reg_w, reg_h, reg_d;
  logic [10:0]                pos_x, pos_y, pos_z;
  logic [10:0]                min_x, max_x, min_y, max_y;
  logic [10:0]                lead_empty, last_hit;
  bit                         slice_seen, volume_seen;

  vtcb_pkg::out_data_t        due_volume_results [$];

  // handshake bookkeeping shared between the edge monitor and the drivers
  bit                         in_fire;
  bit                         clear_seen;
  bit                         row_typed;
  vtcb_pkg::out_data_t        row_want;
  int                         send_pct;
  int                         recv_pct;
  int                         error_count;
  int                         idle_cycles;

  // a zero register acts as one, anything past the largest size is clamped
  function automatic logic [10:0] active_dim(input logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    if (v > 11'(vtcb_pkg::MAX_DIM)) return 11'(vtcb_pkg::MAX_DIM);
    return v;
  endfunction

  function automatic logic [vtcb_pkg::SUM_W-1:0] add_capped(input logic [63:0] a,
                                                            input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'(vtcb_pkg::SUM_MAX)) ? vtcb_pkg::SUM_MAX : s[vtcb_pkg::SUM_W-1:0];
  endfunction

  task automatic restart_volume;
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    min_x       = active_dim(reg_w) - 11'd1;
    max_x       = '0;
    min_y       = active_dim(reg_h) - 11'd1;
    max_y       = '0;
    lead_empty  = '0;
    last_hit    = active_dim(reg_d) - 11'd1;
    slice_seen  = 1'b0;
    volume_seen = 1'b0;
  endtask

  task automatic wipe_volume_state;
    foreach (bin_count[i]) bin_count[i] = '0;
    weight_total = '0;
    weight_run   = '0;
    thr_level    = '0;
    restart_volume();
  endtask

  // a write to a size register drops the box pass in progress, the spare index does nothing
  task automatic apply_register(input logic [vtcb_pkg::CFG_IDX_W-1:0] index,
                                input logic [vtcb_pkg::DIM_W-1:0] value);
    case (index)
      vtcb_pkg::REG_WIDTH: begin
        reg_w = value;
        restart_volume();
      end
      vtcb_pkg::REG_HEIGHT: begin
        reg_h = value;
        restart_volume();
      end
      vtcb_pkg::REG_DEPTH: begin
        reg_d = value;
        restart_volume();
      end
      default: begin
      end
    endcase
  endtask

  // follows one accepted item through histogram, level walk and box trackers
  task automatic trace_voxel_item(input vtcb_pkg::in_data_t item, output bit produced,
                                  output vtcb_pkg::out_data_t res);
    logic [10:0] w, h, d;
    logic [63:0] acc;
    int          t;
    produced = 1'b0;
    res      = '0;
    case (item.command)
      vtcb_pkg::CMD_HIST: begin
        // a full bin stops counting and stops adding weight
        if (bin_count[item.sample] != vtcb_pkg::BIN_MAX) begin
          bin_count[item.sample] = bin_count[item.sample] + 1'b1;
          weight_total = add_capped(64'(weight_total), 64'(item.sample));
        end
      end
      vtcb_pkg::CMD_CLEAR: begin
        wipe_volume_state();
      end
      vtcb_pkg::CMD_THRESH: begin
        // weighted median: first level where twice the running weight passes the total
        acc = '0;
        for (t = 0; t < vtcb_pkg::BIN_COUNT; t++) begin
          acc = 64'(add_capped(acc, 64'(bin_count[t]) * 64'(t)));
          if ((acc << 1) > 64'(weight_total)) break;
        end
        weight_run         = acc[vtcb_pkg::SUM_W-1:0];
        thr_level          = vtcb_pkg::THR_W'(t);
        produced           = 1'b1;
        res.result_kind    = vtcb_pkg::KIND_THRESH;
        res.threshold      = thr_level;
      end
      default: begin
        w = active_dim(reg_w);
        h = active_dim(reg_h);
        d = active_dim(reg_d);
        if (pos_x >= w) pos_x = '0;
        if (pos_y >= h) pos_y = '0;
        if (pos_z >= d) pos_z = '0;
        if (vtcb_pkg::THR_W'(item.sample) > thr_level) begin
          if (pos_x < min_x) min_x = pos_x;
          if (pos_x > max_x) max_x = pos_x;
          if (pos_y < min_y) min_y = pos_y;
          if (pos_y > max_y) max_y = pos_y;
          slice_seen  = 1'b1;
          volume_seen = 1'b1;
        end
        pos_x = pos_x + 11'd1;
        if (pos_x >= w) begin
          pos_x = '0;
          pos_y = pos_y + 11'd1;
          if (pos_y >= h) begin
            pos_y = '0;
            // slice finished: move the back edge or grow the run of leading empties
            if (slice_seen) begin
              last_hit = pos_z;
            end else if (lead_empty == pos_z) begin
              lead_empty = pos_z + 11'd1;
            end
            slice_seen = 1'b0;
            if (pos_z + 11'd1 >= d) begin
              produced        = 1'b1;
              res.result_kind = vtcb_pkg::KIND_BOX;
              res.threshold   = thr_level;
              res.x_low       = 10'((min_x < w - 11'd1) ? min_x : w - 11'd1);
              res.x_high      = 10'(max_x);
              res.y_low       = 10'((min_y < h - 11'd1) ? min_y : h - 11'd1);
              res.y_high      = 10'(max_y);
              res.z_low       = lead_empty;
              res.z_high      = 10'(last_hit);
              res.box_empty   = !volume_seen;
              restart_volume();
            end else begin
              pos_z = pos_z + 11'd1;
            end
          end
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic flag_error(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic check_result(input vtcb_pkg::out_data_t got);
    vtcb_pkg::out_data_t want;
    if (due_volume_results.size() == 0) begin
      flag_error("output transfer with no result outstanding");
      return;
    end
    want = due_volume_results.pop_front();
    compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
    compare_field("threshold", 32'(got.threshold), 32'(want.threshold));
    compare_field("x_low", 32'(got.x_low), 32'(want.x_low));
    compare_field("x_high", 32'(got.x_high), 32'(want.x_high));
    compare_field("y_low", 32'(got.y_low), 32'(want.y_low));
    compare_field("y_high", 32'(got.y_high), 32'(want.y_high));
    compare_field("z_low", 32'(got.z_low), 32'(want.z_low));
    compare_field("z_high", 32'(got.z_high), 32'(want.z_high));
    compare_field("box_empty", 32'(got.box_empty), 32'(want.box_empty));
  endtask

  // --------------------------------------------------------------------------
  // clock, edge monitor, watchdog, receiver
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // both channels sampled at the rising edge; the prediction runs on input transfers
  always @(posedge clk_i) begin
    bit                  produced;
    vtcb_pkg::out_data_t res;
    in_fire = (in_valid_i === 1'b1) && (in_ready_o === 1'b1);
    if (in_fire) begin
      trace_voxel_item(in_data_i, produced, res);
      if (in_data_i.command == vtcb_pkg::CMD_CLEAR) clear_seen = 1'b1;
      // scripted rows with a typed result stand in for the computed one
      if (row_typed) begin
        due_volume_results.push_back(row_want);
      end else if (produced) begin
        due_volume_results.push_back(res);
      end
    end
    if ((out_valid_o === 1'b1) && (out_ready_i === 1'b1)) check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if (((in_valid_i === 1'b1) && (in_ready_o === 1'b1)) ||
        ((out_valid_o === 1'b1) && (out_ready_i === 1'b1))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      flag_error($sformatf("no transfer for %0d cycles, %0d results outstanding",
                           idle_cycles, due_volume_results.size()));
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_pct);
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  // one transfer on the input channel; valid stays up until accepted
  task automatic push_item(input vtcb_pkg::cmd_e command, input logic [15:0] value,
                           input bit typed, input vtcb_pkg::out_data_t want);
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_pct);
    end
    row_typed  = typed;
    row_want   = want;
    in_data_i  <= '{command, value};
    in_valid_i <= 1'b1;
    do @(negedge clk_i); while (!in_fire);
  endtask

  // sender holds off until every outstanding result has been taken
  task automatic hold_for_results;
    if (due_volume_results.size() != 0) begin
      in_valid_i <= 1'b0;
      while (due_volume_results.size() != 0) @(negedge clk_i);
    end
  endtask

  // block idle: results all in, plus time for a clear sweep or queued work
  task automatic settle_block;
    in_valid_i <= 1'b0;
    while (due_volume_results.size() != 0) @(negedge clk_i);
    repeat (clear_seen ? SWEEP_WAIT : SETTLE_WAIT) @(negedge clk_i);
    clear_seen = 1'b0;
  endtask

  task automatic write_reg(input logic [vtcb_pkg::CFG_IDX_W-1:0] index,
                           input logic [vtcb_pkg::DIM_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(negedge clk_i);
    apply_register(index, value);
  endtask

  // new geometry and idle pattern; the spare index is poked each time as well
  task automatic set_volume(input logic [10:0] w, input logic [10:0] h, input logic [10:0] d,
                            input int s_pct, input int r_pct);
    write_reg(vtcb_pkg::REG_WIDTH, w);
    write_reg(vtcb_pkg::REG_HEIGHT, h);
    write_reg(vtcb_pkg::REG_DEPTH, d);
    write_reg(REG_SPARE, vtcb_pkg::DIM_W'($urandom_range(0, 2047)));
    cfg_we_i <= 1'b0;
    send_pct = s_pct;
    recv_pct = r_pct;
  endtask

  // box sample around the current level: anything, close to it, or at or below it
  function automatic logic [15:0] box_value(input int flavour);
    int          near_v;
    logic [16:0] ceiling;
    ceiling = (thr_level > 17'd65535) ? 17'd65535 : thr_level;
    case (flavour)
      0: return 16'($urandom);
      1: begin
        near_v = int'(thr_level) + int'($urandom_range(0, 4)) - 2;
        if (near_v < 0) near_v = 0;
        if (near_v > 65535) near_v = 65535;
        return 16'(near_v);
      end
      default: return 16'($urandom_range(0, ceiling));
    endcase
  endfunction

  // random run on a small volume: mostly voxels, some histogram work and level walks
  task automatic run_mixed(input logic [10:0] w, input logic [10:0] h, input logic [10:0] d,
                           input int s_pct, input int r_pct, input bit with_clear);
    int             n;
    int             pick;
    vtcb_pkg::cmd_e command;
    logic [15:0]    value;
    settle_block();
    set_volume(w, h, d, s_pct, r_pct);
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) hold_for_results();
      pick = $urandom_range(0, 99);
      if (with_clear && n == PHASE_ITEMS / 3) begin
        command = vtcb_pkg::CMD_CLEAR;
        value   = 16'($urandom);
      end else if (pick < 12) begin
        // small levels keep the bin walk short
        command = vtcb_pkg::CMD_HIST;
        value   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                               : 16'($urandom_range(0, 1023));
      end else if (pick < 17) begin
        command = vtcb_pkg::CMD_THRESH;
        value   = 16'($urandom);
        // an empty histogram would walk every bin, feed it instead
        if (weight_total == '0) begin
          command = vtcb_pkg::CMD_HIST;
          value   = 16'($urandom_range(1, 1023));
        end
      end else begin
        command = vtcb_pkg::CMD_BOX;
        value   = box_value($urandom_range(0, 2));
      end
      push_item(command, value, 1'b0, '0);
    end
  endtask

  initial begin
    int i;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    send_pct    = 0;
    recv_pct    = 0;
    error_count = 0;
    idle_cycles = 0;
    clear_seen  = 1'b0;
    row_typed   = 1'b0;
    row_want    = '0;
    reg_w       = vtcb_pkg::DIM_RESET;
    reg_h       = vtcb_pkg::DIM_RESET;
    reg_d       = vtcb_pkg::DIM_RESET;
    wipe_volume_state();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // register writes are taken while the post-reset sweep is still running
    set_volume(11'd2, 11'd1, 11'd2, 0, 0);
    for (i = 0; i < $size(script_rows); i++) begin
      push_item(script_rows[i].command, script_rows[i].sample, script_rows[i].typed,
                script_rows[i].want);
    end

    // random volumes: each idle pattern, zero sizes, one clear
    run_mixed(11'd3, 11'd2, 11'd2, 0, 0, 1'b0);
    run_mixed(11'd0, 11'd0, 11'd0, 73, 0, 1'b0);
    run_mixed(11'd4, 11'd1, 11'd3, 0, 73, 1'b0);
    run_mixed(11'd1, 11'd3, 11'd1, 25, 25, 1'b0);
    run_mixed(11'd2, 11'd2, 11'd1, 25, 25, 1'b1);
    run_mixed(11'd5, 11'd1, 11'd2, 73, 73, 1'b0);

    in_valid_i <= 1'b0;
    while (due_volume_results.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
